// ----- design/addh_pkg.sv -----
`timescale 1ns / 1ps

package addh_pkg;

  localparam int CAPACITY  = 256;
  localparam int SLOT_W    = 8;
  localparam int ID_W      = 8;
  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 9;
  localparam int ARITY_W   = 4;
  localparam int MAX_ARITY = 8;
  localparam int PROD_W    = 12;
  localparam int ENTRY_W   = KEY_W + ID_W;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_INSERT = 3'd0;
  localparam opcode_t OP_POP    = 3'd1;
  localparam opcode_t OP_DELETE = 3'd2;
  localparam opcode_t OP_CHANGE = 3'd3;
  localparam opcode_t OP_PEEK   = 3'd4;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_FULL    = 3'd1;
  localparam status_t ST_EMPTY   = 3'd2;
  localparam status_t ST_ABSENT  = 3'd3;
  localparam status_t ST_PRESENT = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POS_WAIT,
    S_OLD_WAIT,
    S_RM_LAST,
    S_SU_CHK,
    S_SU_CMP,
    S_SD_CHK,
    S_SD_SCAN,
    S_SD_DEC,
    S_DONE
  } state_t;

  function automatic logic above(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic logic [ARITY_W-1:0] eff_arity(logic [ARITY_W-1:0] a);
    logic [ARITY_W-1:0] d;
    d = a;
    if (a < ARITY_W'(2)) d = ARITY_W'(2);
    if (a > ARITY_W'(MAX_ARITY)) d = ARITY_W'(MAX_ARITY);
    return d;
  endfunction

  // Quotient x / d for d in 2..8 through shifts or reciprocal multiplies,
  // exact for every 8-bit x.
  function automatic logic [SLOT_W-1:0] parent_of(logic [SLOT_W-1:0] x,
                                                  logic [ARITY_W-1:0] d);
    logic [17:0] m3;
    logic [17:0] m5;
    logic [17:0] m7;
    logic [SLOT_W-1:0] q;
    m3 = 18'(x) * 18'd171;
    m5 = 18'(x) * 18'd205;
    m7 = 18'(x) * 18'd293;
    case (d)
      4'd2:    q = x >> 1;
      4'd3:    q = m3[16:9];
      4'd4:    q = x >> 2;
      4'd5:    q = m5[17:10];
      4'd6:    q = m3[17:10];
      4'd7:    q = {1'b0, m7[17:11]};
      default: q = x >> 3;
    endcase
    return q;
  endfunction

endpackage

// ----- design/addressable_dary_heap.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// command   opcode, entry_key, entry_id                  start while busy is low
// result    status, top_valid, top_key, top_id,          done, one cycle
//           entry_count
// config    psel, penable, pwrite, paddr, pwdata, prdata  APB, pready tied high
//
// One command at a time. Each sift-up level passes through S_SU_CHK and
// S_SU_CMP, each sift-down level through S_SD_CHK, S_SD_SCAN for every
// child and S_SD_DEC, both set by the single read port of the slot memory.
// Delete and change first look up the position in S_POS_WAIT and
// S_OLD_WAIT; a peek or an error goes straight to S_DONE. Reset empties
// the heap at once (presence bits in flops), with no clearing pass.
// The receiver cannot stall done.
module addressable_dary_heap (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   opcode,
  input  logic signed [31:0]           entry_key,
  input  logic [7:0]                   entry_id,
  output logic                         done,
  output logic [2:0]                   status,
  output logic                         top_valid,
  output logic signed [31:0]           top_key,
  output logic [7:0]                   top_id,
  output logic [8:0]                   entry_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  addh_pkg::state_t state, state_next;

  logic [addh_pkg::ARITY_W-1:0]  arity;
  logic [addh_pkg::COUNT_W-1:0]  fill, fill_next;
  logic [addh_pkg::CAPACITY-1:0] present, present_next;
  addh_pkg::opcode_t             op, op_next;
  logic [addh_pkg::KEY_W-1:0]    cur_key, cur_key_next;
  logic [addh_pkg::ID_W-1:0]     cur_id, cur_id_next;
  logic [addh_pkg::SLOT_W-1:0]   s, s_next;
  logic [addh_pkg::SLOT_W-1:0]   par, par_next;
  logic [addh_pkg::KEY_W-1:0]    gone_key, gone_key_next;
  logic [addh_pkg::SLOT_W-1:0]   c, c_next;
  logic [addh_pkg::SLOT_W-1:0]   last_c, last_c_next;
  logic [addh_pkg::SLOT_W-1:0]   best, best_next;
  logic [addh_pkg::KEY_W-1:0]    best_key, best_key_next;
  logic [addh_pkg::ID_W-1:0]     best_id, best_id_next;
  logic                          scan_first, scan_first_next;
  addh_pkg::status_t             res_status, res_status_next;
  logic                          popped, popped_next;
  logic [addh_pkg::KEY_W-1:0]    pop_key, pop_key_next;
  logic [addh_pkg::ID_W-1:0]     pop_id, pop_id_next;
  logic [addh_pkg::KEY_W-1:0]    head_key;
  logic [addh_pkg::ID_W-1:0]     head_id;

  // Slot memory holds {key, id}; position memory maps id to slot.
  logic [addh_pkg::ENTRY_W-1:0] heap_mem [addh_pkg::CAPACITY];
  logic [addh_pkg::SLOT_W-1:0]  pos_mem  [addh_pkg::CAPACITY];
  logic                         heap_we, pos_we;
  logic [addh_pkg::SLOT_W-1:0]  heap_wa, heap_ra;
  logic [addh_pkg::ENTRY_W-1:0] heap_wd, heap_rdata;
  logic [addh_pkg::ID_W-1:0]    pos_wa, pos_ra;
  logic [addh_pkg::SLOT_W-1:0]  pos_wd, pos_rdata;

  logic [addh_pkg::ARITY_W-1:0] d;
  logic [addh_pkg::PROD_W-1:0]  prod, first, last_full;
  logic [addh_pkg::COUNT_W-1:0] fill_m1;
  logic [addh_pkg::KEY_W-1:0]   rkey;
  logic [addh_pkg::ID_W-1:0]    rid;

  assign d         = addh_pkg::eff_arity(arity);
  assign prod      = addh_pkg::PROD_W'(s) * addh_pkg::PROD_W'(d);
  assign first     = prod + addh_pkg::PROD_W'(1);
  assign last_full = prod + addh_pkg::PROD_W'(d);
  assign fill_m1   = fill - addh_pkg::COUNT_W'(1);
  assign rkey      = heap_rdata[addh_pkg::ENTRY_W-1:addh_pkg::ID_W];
  assign rid       = heap_rdata[addh_pkg::ID_W-1:0];

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rdata <= heap_mem[heap_ra];
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rdata <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= addh_pkg::S_IDLE;
      fill    <= '0;
      present <= '0;
      arity   <= addh_pkg::ARITY_W'(2);
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      present <= present_next;
      if (psel && penable && pwrite && paddr == 2'd0) begin
        arity <= pwdata[addh_pkg::ARITY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    cur_key    <= cur_key_next;
    cur_id     <= cur_id_next;
    s          <= s_next;
    par        <= par_next;
    gone_key   <= gone_key_next;
    c          <= c_next;
    last_c     <= last_c_next;
    best       <= best_next;
    best_key   <= best_key_next;
    best_id    <= best_id_next;
    scan_first <= scan_first_next;
    res_status <= res_status_next;
    popped     <= popped_next;
    pop_key    <= pop_key_next;
    pop_id     <= pop_id_next;
    // Keep a copy of slot 0 so the top is always at hand.
    if (heap_we && heap_wa == '0) begin
      head_key <= heap_wd[addh_pkg::ENTRY_W-1:addh_pkg::ID_W];
      head_id  <= heap_wd[addh_pkg::ID_W-1:0];
    end
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    present_next    = present;
    op_next         = op;
    cur_key_next    = cur_key;
    cur_id_next     = cur_id;
    s_next          = s;
    par_next        = par;
    gone_key_next   = gone_key;
    c_next          = c;
    last_c_next     = last_c;
    best_next       = best;
    best_key_next   = best_key;
    best_id_next    = best_id;
    scan_first_next = scan_first;
    res_status_next = res_status;
    popped_next     = popped;
    pop_key_next    = pop_key;
    pop_id_next     = pop_id;
    heap_we         = 1'b0;
    heap_wa         = s;
    heap_wd         = {cur_key, cur_id};
    heap_ra         = s;
    pos_we          = 1'b0;
    pos_wa          = cur_id;
    pos_wd          = s;
    pos_ra          = entry_id;

    unique case (state)
      addh_pkg::S_IDLE: begin
        if (start) begin
          op_next         = opcode;
          cur_key_next    = entry_key;
          cur_id_next     = entry_id;
          res_status_next = addh_pkg::ST_OK;
          popped_next     = 1'b0;
          state_next      = addh_pkg::S_DONE;
          priority if (opcode == addh_pkg::OP_INSERT) begin
            if (fill == addh_pkg::COUNT_W'(addh_pkg::CAPACITY)) begin
              res_status_next = addh_pkg::ST_FULL;
            end else if (present[entry_id]) begin
              res_status_next = addh_pkg::ST_PRESENT;
            end else begin
              present_next[entry_id] = 1'b1;
              fill_next  = fill + addh_pkg::COUNT_W'(1);
              s_next     = fill[addh_pkg::SLOT_W-1:0];
              state_next = addh_pkg::S_SU_CHK;
            end
          end else if (opcode == addh_pkg::OP_POP) begin
            if (fill == '0) begin
              res_status_next = addh_pkg::ST_EMPTY;
            end else begin
              popped_next           = 1'b1;
              pop_key_next          = head_key;
              pop_id_next           = head_id;
              present_next[head_id] = 1'b0;
              gone_key_next         = head_key;
              s_next                = '0;
              heap_ra               = fill_m1[addh_pkg::SLOT_W-1:0];
              fill_next             = fill_m1;
              if (fill_m1 != '0) begin
                state_next = addh_pkg::S_RM_LAST;
              end
            end
          end else if (opcode == addh_pkg::OP_DELETE || opcode == addh_pkg::OP_CHANGE) begin
            if (!present[entry_id]) begin
              res_status_next = addh_pkg::ST_ABSENT;
            end else begin
              state_next = addh_pkg::S_POS_WAIT;
            end
          end else if (opcode == addh_pkg::OP_PEEK) begin
            if (fill == '0) begin
              res_status_next = addh_pkg::ST_EMPTY;
            end
          end else begin
            res_status_next = addh_pkg::ST_OK;
          end
        end
      end

      addh_pkg::S_POS_WAIT: begin
        s_next     = pos_rdata;
        heap_ra    = pos_rdata;
        state_next = addh_pkg::S_OLD_WAIT;
      end

      addh_pkg::S_OLD_WAIT: begin
        if (op == addh_pkg::OP_DELETE) begin
          present_next[cur_id] = 1'b0;
          gone_key_next        = rkey;
          fill_next            = fill_m1;
          heap_ra              = fill_m1[addh_pkg::SLOT_W-1:0];
          if ({1'b0, s} == fill_m1) begin
            state_next = addh_pkg::S_DONE;
          end else begin
            state_next = addh_pkg::S_RM_LAST;
          end
        end else if (rkey == cur_key) begin
          state_next = addh_pkg::S_DONE;
        end else if (addh_pkg::above(cur_key, rkey)) begin
          state_next = addh_pkg::S_SU_CHK;
        end else begin
          state_next = addh_pkg::S_SD_CHK;
        end
      end

      // The last entry moves into the hole and sifts whichever way it must.
      addh_pkg::S_RM_LAST: begin
        cur_key_next = rkey;
        cur_id_next  = rid;
        if (!addh_pkg::above(gone_key, rkey)) begin
          state_next = addh_pkg::S_SU_CHK;
        end else begin
          state_next = addh_pkg::S_SD_CHK;
        end
      end

      addh_pkg::S_SU_CHK: begin
        if (s == '0) begin
          heap_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = addh_pkg::S_DONE;
        end else begin
          par_next   = addh_pkg::parent_of(s - addh_pkg::SLOT_W'(1), d);
          heap_ra    = par_next;
          state_next = addh_pkg::S_SU_CMP;
        end
      end

      addh_pkg::S_SU_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (addh_pkg::above(cur_key, rkey)) begin
          heap_wd    = heap_rdata;
          pos_wa     = rid;
          s_next     = par;
          state_next = addh_pkg::S_SU_CHK;
        end else begin
          state_next = addh_pkg::S_DONE;
        end
      end

      addh_pkg::S_SD_CHK: begin
        if (first >= addh_pkg::PROD_W'(fill)) begin
          heap_we    = 1'b1;
          pos_we     = 1'b1;
          state_next = addh_pkg::S_DONE;
        end else begin
          c_next          = first[addh_pkg::SLOT_W-1:0];
          heap_ra         = first[addh_pkg::SLOT_W-1:0];
          scan_first_next = 1'b1;
          if (last_full > addh_pkg::PROD_W'(fill_m1)) begin
            last_c_next = fill_m1[addh_pkg::SLOT_W-1:0];
          end else begin
            last_c_next = last_full[addh_pkg::SLOT_W-1:0];
          end
          state_next = addh_pkg::S_SD_SCAN;
        end
      end

      // One child arrives per cycle while the next one is read; ties keep
      // the lower slot.
      addh_pkg::S_SD_SCAN: begin
        scan_first_next = 1'b0;
        if (scan_first || addh_pkg::above(rkey, best_key)) begin
          best_next     = c;
          best_key_next = rkey;
          best_id_next  = rid;
        end
        if (c == last_c) begin
          state_next = addh_pkg::S_SD_DEC;
        end else begin
          c_next  = c + addh_pkg::SLOT_W'(1);
          heap_ra = c_next;
        end
      end

      addh_pkg::S_SD_DEC: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (addh_pkg::above(best_key, cur_key)) begin
          heap_wd    = {best_key, best_id};
          pos_wa     = best_id;
          s_next     = best;
          state_next = addh_pkg::S_SD_CHK;
        end else begin
          state_next = addh_pkg::S_DONE;
        end
      end

      addh_pkg::S_DONE: begin
        state_next = addh_pkg::S_IDLE;
      end

      default: begin
        state_next = addh_pkg::S_IDLE;
      end
    endcase
  end

  assign busy        = state != addh_pkg::S_IDLE;
  assign done        = state == addh_pkg::S_DONE;
  assign status      = res_status;
  assign top_valid   = fill != '0;
  assign entry_count = fill;
  assign top_key     = popped ? pop_key : (top_valid ? head_key : '0);
  assign top_id      = popped ? pop_id : (top_valid ? head_id : '0);

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32 - addh_pkg::ARITY_W){1'b0}}, arity} : '0;

endmodule

// ----- design/addh_checker.sv -----
`timescale 1ns / 1ps

module addh_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic        top_valid,
  input logic [31:0] top_key,
  input logic [7:0]  top_id,
  input logic [8:0]  entry_count
);

  // A word is reported once per command, never in back-to-back cycles.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (top_valid == (entry_count != 9'd0)))
    else $error("top_valid disagrees with entry_count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= 9'd256))
    else $error("entry_count above capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == 3'd2) |-> (!top_valid && top_key == 32'd0 && top_id == 8'd0))
    else $error("empty status with a reported entry");

endmodule

bind addressable_dary_heap addh_checker u_addh_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done),
  .status(status),
  .top_valid(top_valid),
  .top_key(top_key),
  .top_id(top_id),
  .entry_count(entry_count)
);
